// ----- hw/rtl/htw_pkg.sv -----
package htw_pkg;

    localparam int WHEEL_SLOTS_DEF = 16;
    localparam int MAX_TIMERS_DEF  = 32;

    localparam int MODE_W     = 2;
    localparam int ID_W       = 5;
    localparam int INTERVAL_W = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK   = 2'd0,
        MODE_ARM    = 2'd1,
        MODE_DISARM = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_LOAD,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        mode_t                 mode;
        logic [ID_W-1:0]       timer_id;
        logic [INTERVAL_W-1:0] interval;
    } in_t;

    typedef struct packed {
        logic [ID_W-1:0] expired_id;
        logic            last;
    } out_t;

    typedef struct packed {
        logic tick;
        logic arm;
        logic disarm;
        logic shift;
    } cell_ctl_t;

endpackage

// ----- hw/rtl/htw_cell.sv -----
module htw_cell #(
    parameter int WHEEL_SLOTS = htw_pkg::WHEEL_SLOTS_DEF,
    parameter int SLOT_W      = $clog2(WHEEL_SLOTS),
    parameter int ROUND_W     = 12
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  htw_pkg::cell_ctl_t ctl,
    input  logic               sel,
    input  logic [SLOT_W-1:0]  cur,
    input  logic [SLOT_W-1:0]  offset,
    input  logic [ROUND_W-1:0] reload,
    input  logic               flag_in,
    output logic               flag_out
);

    localparam logic [SLOT_W:0] SLOTS = (SLOT_W+1)'(WHEEL_SLOTS);

    logic               valid_reg, valid_next;
    logic               flag_reg, flag_next;
    logic [SLOT_W-1:0]  off_reg, off_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [ROUND_W-1:0] rounds_reg, rounds_next;
    logic [ROUND_W-1:0] reload_reg, reload_next;

    logic               hit;
    logic               expire;
    logic [SLOT_W:0]    sum_rearm;
    logic [SLOT_W:0]    sum_arm;
    logic [SLOT_W-1:0]  slot_rearm;
    logic [SLOT_W-1:0]  slot_arm;

    assign hit       = valid_reg && (slot_reg == cur);
    assign expire    = hit && (rounds_reg == '0);
    assign sum_rearm = {1'b0, cur} + {1'b0, off_reg};
    assign sum_arm   = {1'b0, cur} + {1'b0, offset};
    assign slot_rearm = (sum_rearm >= SLOTS) ? SLOT_W'(sum_rearm - SLOTS) : SLOT_W'(sum_rearm);
    assign slot_arm   = (sum_arm >= SLOTS) ? SLOT_W'(sum_arm - SLOTS) : SLOT_W'(sum_arm);
    assign flag_out  = flag_reg;

    always_comb begin
        valid_next  = valid_reg;
        flag_next   = flag_reg;
        off_next    = off_reg;
        slot_next   = slot_reg;
        rounds_next = rounds_reg;
        reload_next = reload_reg;
        if (ctl.tick) begin
            flag_next = expire;
            if (hit) begin
                if (rounds_reg != '0) begin
                    rounds_next = rounds_reg - 1'b1;
                end else begin
                    slot_next   = slot_rearm;
                    rounds_next = reload_reg;
                end
            end
        end
        if (ctl.shift) begin
            flag_next = flag_in;
        end
        if (sel && ctl.arm) begin
            valid_next  = 1'b1;
            off_next    = offset;
            reload_next = reload;
            slot_next   = slot_arm;
            rounds_next = reload;
        end
        if (sel && ctl.disarm) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            flag_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            flag_reg  <= flag_next;
        end
        off_reg    <= off_next;
        slot_reg   <= slot_next;
        rounds_reg <= rounds_next;
        reload_reg <= reload_next;
    end

endmodule

// ----- hw/rtl/hashed_timing_wheel.sv -----
// Arm: accept, then reciprocal multiply for rounds, then offset and table load.
// Disarm and unused mode are handled at accept; the wheel stays idle.
// Tick: all timer cells update in the accept cycle, then expiry flags shift down the
// cell chain one position per cycle, stalling while an expiry waits on a busy output;
// expiries leave in timer order and the input stays blocked until no flag is left.
// Synchronous active-low reset clears the slot pointer, timer valid bits, expiry
// flags and the output valid bit; no clearing pass is needed.
module hashed_timing_wheel #(
    parameter int WHEEL_SLOTS = htw_pkg::WHEEL_SLOTS_DEF,
    parameter int MAX_TIMERS  = htw_pkg::MAX_TIMERS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  htw_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output htw_pkg::out_t  m_data
);

    localparam int IV_W    = htw_pkg::INTERVAL_W;
    localparam int SLOT_W  = $clog2(WHEEL_SLOTS);
    localparam int ROUND_W = $clog2(65535 / WHEEL_SLOTS + 1);
    localparam int CNT_W   = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int REC_SH  = IV_W + SLOT_W;
    localparam longint RECIP_L = ((longint'(1) << REC_SH) + longint'(WHEEL_SLOTS) - 1)
                                 / longint'(WHEEL_SLOTS);
    localparam logic [IV_W:0]     RECIP     = (IV_W+1)'(RECIP_L);
    localparam logic [IV_W-1:0]   SLOTS_IV  = IV_W'(WHEEL_SLOTS);
    localparam logic [IV_W-1:0]   REM_TOP   = IV_W'(WHEEL_SLOTS - 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WHEEL_SLOTS - 1);

    htw_pkg::state_t    state_reg, state_next;
    htw_pkg::cell_ctl_t ctl;

    logic [SLOT_W-1:0]  cur_reg, cur_next;
    logic [SLOT_W-1:0]  cur_cell;
    logic [CNT_W-1:0]   id_reg, id_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   target;
    logic [IV_W-1:0]    dvd_reg, dvd_next;
    logic [IV_W-1:0]    quo_reg, quo_next;
    logic               m_valid_reg, m_valid_next;
    htw_pkg::out_t      m_data_reg, m_data_next;

    logic               accept;
    logic               in_range;
    logic [2*IV_W:0]    prod;
    logic [IV_W-1:0]    back;
    logic [IV_W-1:0]    rem;
    logic [SLOT_W-1:0]  offset;
    logic [ROUND_W-1:0] reload;
    logic [MAX_TIMERS-1:0] flags;
    logic [MAX_TIMERS-1:0] flag_chain;
    logic               any_flag;
    logic               more_flags;
    logic               out_free;
    logic               out_load;

    assign accept   = s_valid && s_ready;
    assign in_range = 32'(s_data.timer_id) < MAX_TIMERS;
    assign prod     = {{(IV_W+1){1'b0}}, dvd_reg} * {{IV_W{1'b0}}, RECIP};
    assign back     = quo_reg * SLOTS_IV;
    assign rem      = dvd_reg - back;
    assign offset   = (rem == REM_TOP) ? '0 : SLOT_W'(rem + 1'b1);
    assign reload   = ROUND_W'(quo_reg);
    assign any_flag   = |flags;
    assign more_flags = |(flags >> 1);
    assign out_free   = !m_valid_reg || m_ready;
    assign out_load   = (state_reg == htw_pkg::ST_DRAIN) && flags[0] && out_free;
    assign cur_cell   = ctl.tick ? ((cur_reg == LAST_SLOT) ? '0 : SLOT_W'(cur_reg + 1'b1))
                                 : cur_reg;
    assign target     = (state_reg == htw_pkg::ST_LOAD) ? id_reg : CNT_W'(s_data.timer_id);

    assign s_ready = (state_reg == htw_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            htw_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (s_data.mode)
                        htw_pkg::MODE_TICK: state_next = htw_pkg::ST_DRAIN;
                        htw_pkg::MODE_ARM:  state_next = in_range ? htw_pkg::ST_DIV
                                                                  : htw_pkg::ST_IDLE;
                        default:            state_next = htw_pkg::ST_IDLE;
                    endcase
                end
            end
            htw_pkg::ST_DIV:  state_next = htw_pkg::ST_LOAD;
            htw_pkg::ST_LOAD: state_next = htw_pkg::ST_IDLE;
            htw_pkg::ST_DRAIN: begin
                if (!any_flag) begin
                    state_next = htw_pkg::ST_IDLE;
                end
            end
            default: state_next = htw_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        ctl = '0;
        unique case (state_reg)
            htw_pkg::ST_IDLE: begin
                ctl.tick   = accept && (s_data.mode == htw_pkg::MODE_TICK);
                ctl.disarm = accept && (s_data.mode == htw_pkg::MODE_DISARM) && in_range;
            end
            htw_pkg::ST_LOAD:  ctl.arm   = 1'b1;
            htw_pkg::ST_DRAIN: ctl.shift = !flags[0] || out_free;
            default: ;
        endcase
    end

    always_comb begin
        cur_next     = ctl.tick ? cur_cell : cur_reg;
        id_next      = id_reg;
        cnt_next     = cnt_reg;
        dvd_next     = dvd_reg;
        quo_next     = quo_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (accept && (s_data.mode == htw_pkg::MODE_ARM)) begin
            id_next  = CNT_W'(s_data.timer_id);
            dvd_next = (s_data.interval == '0) ? '0 : s_data.interval - 1'b1;
        end
        if (state_reg == htw_pkg::ST_DIV) begin
            quo_next = IV_W'(prod >> REC_SH);
        end
        if (ctl.tick) begin
            cnt_next = '0;
        end
        if (ctl.shift) begin
            cnt_next = cnt_reg + 1'b1;
        end
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (out_load) begin
            m_valid_next           = 1'b1;
            m_data_next.expired_id = htw_pkg::ID_W'(cnt_reg);
            m_data_next.last       = !more_flags;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= htw_pkg::ST_IDLE;
            cur_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cur_reg     <= cur_next;
            m_valid_reg <= m_valid_next;
        end
        id_reg     <= id_next;
        cnt_reg    <= cnt_next;
        dvd_reg    <= dvd_next;
        quo_reg    <= quo_next;
        m_data_reg <= m_data_next;
    end

    assign flag_chain = flags >> 1;

    for (genvar i = 0; i < MAX_TIMERS; i++) begin : g_cell
        htw_cell #(
            .WHEEL_SLOTS (WHEEL_SLOTS),
            .SLOT_W      (SLOT_W),
            .ROUND_W     (ROUND_W)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .sel      (target == CNT_W'(i)),
            .cur      (cur_cell),
            .offset   (offset),
            .reload   (reload),
            .flag_in  (flag_chain[i]),
            .flag_out (flags[i])
        );
    end

endmodule

// ----- tb/tb_hashed_timing_wheel.sv -----
`timescale 1ns / 100ps

module tb_hashed_timing_wheel;

    localparam int SLOTS        = htw_pkg::WHEEL_SLOTS_DEF;
    localparam int TIMERS       = htw_pkg::MAX_TIMERS_DEF;
    localparam int ID_W         = htw_pkg::ID_W;
    localparam int IV_W         = htw_pkg::INTERVAL_W;
    localparam int RANDOM_ITEMS = 250;
    localparam int DRAIN_CYCLES = 40;
    localparam int LIMIT_CYCLES = 400000;
    localparam int MAX_REPORTS  = 10;

    localparam logic [htw_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    class wheel_model;
        bit                  armed[TIMERS];
        int                  period[TIMERS];
        int                  slot[TIMERS];
        int                  rounds[TIMERS];
        int                  cur_slot;
        htw_pkg::out_t       expected_expiries[$];
        int                  errors;

        function new();
            cur_slot = 0;
            errors   = 0;
            foreach (armed[i]) armed[i] = 1'b0;
        endfunction

        function void place(int id, int p);
            period[id] = p;
            slot[id]   = (cur_slot + p) % SLOTS;
            rounds[id] = (p - 1) / SLOTS;
            armed[id]  = 1'b1;
        endfunction

        function void note_transfer(htw_pkg::in_t item);
            htw_pkg::out_t fired[$];
            htw_pkg::out_t e;
            int            p;
            case (item.mode)
                htw_pkg::MODE_ARM: begin
                    p = (item.interval == '0) ? 1 : int'(item.interval);
                    if (item.timer_id < TIMERS) place(int'(item.timer_id), p);
                end
                htw_pkg::MODE_DISARM: begin
                    if (item.timer_id < TIMERS) armed[item.timer_id] = 1'b0;
                end
                htw_pkg::MODE_TICK: begin
                    cur_slot = (cur_slot + 1) % SLOTS;
                    for (int i = 0; i < TIMERS; i++) begin
                        if (armed[i] && slot[i] == cur_slot) begin
                            if (rounds[i] != 0) begin
                                rounds[i]--;
                            end else begin
                                e.expired_id = ID_W'(i);
                                e.last       = 1'b0;
                                fired        = {fired, e};
                                place(i, period[i]);
                            end
                        end
                    end
                    if (fired.size() > 0) fired[fired.size()-1].last = 1'b1;
                    expected_expiries = {expected_expiries, fired};
                end
                default: ;
            endcase
        endfunction

        function void check_expiry(htw_pkg::out_t got);
            htw_pkg::out_t want;
            if (expected_expiries.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected expiry: id %0d last %0d", got.expired_id, got.last);
            end else begin
                want = expected_expiries.pop_front();
                if (got.expired_id !== want.expired_id || got.last !== want.last) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("expiry mismatch: expected id %0d last %0d, got id %0d last %0d",
                                 want.expired_id, want.last, got.expired_id, got.last);
                end
            end
        endfunction

        function int pending();
            return expected_expiries.size();
        endfunction
    endclass

    logic          aclk    = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    htw_pkg::in_t  s_data  = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    htw_pkg::out_t m_data;
    bit            quiet   = 1'b0;
    int unsigned   cycles  = 0;
    wheel_model    wheel   = new();

    hashed_timing_wheel dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("** hashed_timing_wheel: FAILED **");
            $finish;
        end
    end

    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, 3);
    endfunction

    function automatic int draw_interval();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 65535);
            1:       return SLOTS * $urandom_range(1, 4);
            default: return $urandom_range(1, 40);
        endcase
    endfunction

    function automatic htw_pkg::in_t make_item(htw_pkg::mode_t m, int id, int iv);
        htw_pkg::in_t item;
        item.mode     = m;
        item.timer_id = ID_W'(id);
        item.interval = IV_W'(iv);
        return item;
    endfunction

    task automatic send_item(htw_pkg::in_t item);
        int gap;
        gap = draw_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data  <= item;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        wheel.note_transfer(item);
    endtask

    task automatic hold_until_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (wheel.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            stall = draw_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            wheel.check_expiry(m_data);
        end
    end

    initial begin
        htw_pkg::in_t item;
        int           n;
        int           choice;
        int           iv;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_item(make_item(htw_pkg::MODE_ARM, 0, 1));
        send_item(make_item(htw_pkg::MODE_ARM, 31, 0));
        send_item(make_item(htw_pkg::MODE_ARM, 5, SLOTS));
        send_item(make_item(htw_pkg::MODE_ARM, 6, 2 * SLOTS));
        send_item(make_item(htw_pkg::MODE_ARM, 7, 65535));
        send_item(make_item(htw_pkg::MODE_ARM, 8, SLOTS + 1));
        send_item(make_item(htw_pkg::MODE_DISARM, 9, 0));
        item      = make_item(htw_pkg::MODE_TICK, 21, 16'hAAAA);
        item.mode = htw_pkg::mode_t'(MODE_UNUSED);
        send_item(item);
        send_item(make_item(htw_pkg::MODE_ARM, 0, 3));
        send_item(make_item(htw_pkg::MODE_DISARM, 7, 16'h5555));
        repeat (2 * SLOTS + 1) send_item(make_item(htw_pkg::MODE_TICK, 0, 0));
        hold_until_drained();

        n = 0;
        while (n < RANDOM_ITEMS) begin
            if (n % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
            choice = $urandom_range(0, 99);
            if (choice < 2) begin
                iv = $urandom_range(1, 20);
                for (int k = 0; k < TIMERS; k++)
                    send_item(make_item(htw_pkg::MODE_ARM, k, iv));
                n += TIMERS;
            end else begin
                if (choice < 55) begin
                    item = make_item(htw_pkg::MODE_TICK, $urandom_range(0, 31),
                                     $urandom_range(0, 65535));
                end else if (choice < 85) begin
                    item = make_item(htw_pkg::MODE_ARM, $urandom_range(0, 31),
                                     draw_interval());
                end else if (choice < 97) begin
                    item = make_item(htw_pkg::MODE_DISARM, $urandom_range(0, 31),
                                     $urandom_range(0, 65535));
                end else begin
                    item      = make_item(htw_pkg::MODE_TICK, $urandom_range(0, 31),
                                          $urandom_range(0, 65535));
                    item.mode = htw_pkg::mode_t'(MODE_UNUSED);
                end
                send_item(item);
                n++;
            end
            if ($urandom_range(0, 59) == 0) hold_until_drained();
        end

        hold_until_drained();
        if (wheel.errors == 0 && wheel.pending() == 0) begin
            $display("** hashed_timing_wheel: PASSED **");
        end else begin
            $display("** hashed_timing_wheel: FAILED **");
        end
        $finish;
    end

endmodule
